// ===== rtl/core/bounded_deque_with_insert_after_macros.svh =====
// Assertion macros shared by the bounded deque RTL.
`ifndef BOUNDED_DEQUE_WITH_INSERT_AFTER_MACROS_SVH
`define BOUNDED_DEQUE_WITH_INSERT_AFTER_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define BDQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/bdq_pkg.sv =====
// Package with the operation codes, status codes and cell control types of the deque.
package bdq_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_INSERT     = 3'd2,
    FN_POP_FRONT  = 3'd3,
    FN_POP_BACK   = 3'd4,
    FN_READ_ALL   = 3'd5,
    FN_COUNT      = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CMD_NONE       = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_BACK  = 3'd2,
    CMD_INSERT     = 3'd3,
    CMD_ROTATE     = 3'd4
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [DataW-1:0]  value;
    logic [DataW-1:0]  key;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/bdq_cell.sv =====
// One storage cell of the deque chain: holds one element and shifts with its neighbors.
module bdq_cell #(
  parameter int unsigned CW    = 5,
  parameter int unsigned INDEX = 0
) (
  input  logic                        clk,
  input  bdq_pkg::cell_ctrl_t         ctrl,
  input  logic [CW-1:0]               count,
  input  logic [bdq_pkg::DataW-1:0]   head,
  input  logic [bdq_pkg::DataW-1:0]   left_data,
  input  logic [bdq_pkg::DataW-1:0]   right_data,
  input  logic                        seen_prev,
  input  logic                        seen_in,
  output logic                        seen_out,
  input  logic [bdq_pkg::DataW-1:0]   tail_in,
  output logic [bdq_pkg::DataW-1:0]   tail_out,
  output logic [bdq_pkg::DataW-1:0]   data
);

  logic [CW-1:0]             my_index;
  logic                      occupied;
  logic                      is_last;
  logic [bdq_pkg::DataW-1:0] data_next;

  assign my_index = CW'(INDEX);
  assign occupied = my_index < count;
  assign is_last  = (my_index + CW'(1)) == count;

  // A cell past an earlier match, as seen from the front, moves one place back.
  assign seen_out = seen_in | (occupied && (data == ctrl.key));
  assign tail_out = tail_in | (is_last ? data : '0);

  always_comb begin
    data_next = data;
    unique case (ctrl.cmd)
      bdq_pkg::CMD_PUSH_FRONT: begin
        data_next = (INDEX == 0) ? ctrl.value : left_data;
      end
      bdq_pkg::CMD_PUSH_BACK: begin
        if (my_index == count) begin
          data_next = ctrl.value;
        end
      end
      bdq_pkg::CMD_INSERT: begin
        if (seen_in) begin
          data_next = seen_prev ? left_data : ctrl.value;
        end
      end
      bdq_pkg::CMD_ROTATE: begin
        data_next = is_last ? head : right_data;
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== rtl/core/bounded_deque_with_insert_after.sv =====
// Bounded deque with insert-after-key, built as a chain of shifting cells.
//
// Input items arrive on s_tvalid/s_tready/s_tdata; each names one operation:
// push front, push back, insert after the first element equal to key, pop
// front, pop back, read out the whole list, or report the count.
// Results leave on m_tvalid/m_tready/m_tdata with m_tlast marking the final
// result of an operation. Every result carries a status and the length after
// the operation.
// Each operation other than a read-out is done in the cycle its item is
// accepted; its result is valid on the next cycle, and the next item can be
// accepted as soon as the output is free. A read-out of N elements gives N
// results, one per element, since the chain rotates by one cell per cycle
// while the output is free, and emits the front cell; no item is accepted
// meanwhile. The key search is combinational through all CAPACITY cells.
// Reset empties the list at once. When the receiver stalls, the result waits
// in the output register and no further item is taken.
module bounded_deque_with_insert_after #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // func[2:0], value[34:3], key[66:35], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // status[1:0], element[33:2], length[38:34], zero fill
  output logic        m_tlast
);

  `include "bounded_deque_with_insert_after_macros.svh"

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_RUN  = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t                    state, state_next;
  logic [CW-1:0]             count, count_next;
  logic [CW-1:0]             rem, rem_next;
  bdq_pkg::cell_ctrl_t       ctrl;
  bdq_pkg::func_t            func;
  logic [bdq_pkg::DataW-1:0] data [CAPACITY];
  logic                      seen [CAPACITY+1];
  logic [bdq_pkg::DataW-1:0] tail [CAPACITY+1];
  logic [bdq_pkg::DataW-1:0] head;
  logic                      free, accept, load, full, empty, found;
  bdq_pkg::status_t          res_status, status;
  logic [bdq_pkg::DataW-1:0] res_element, element;
  logic                      res_last, last;
  logic [4:0]                length;

  assign func     = bdq_pkg::func_t'(s_tdata[2:0]);
  assign free     = !m_tvalid || m_tready;
  assign s_tready = (state == S_RUN) && free;
  assign accept   = s_tvalid && s_tready;
  assign full     = count == CW'(CAPACITY);
  assign empty    = count == '0;
  assign head     = data[0];
  assign found    = seen[CAPACITY];
  assign seen[0]  = 1'b0;
  assign tail[0]  = '0;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      bdq_cell #(
        .CW    (CW),
        .INDEX (i)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .count      (count),
        .head       (head),
        .left_data  ((i == 0) ? ctrl.value : data[(i == 0) ? 0 : i - 1]),
        .right_data (data[(i == CAPACITY - 1) ? i : i + 1]),
        .seen_prev  ((i == 0) ? 1'b0 : seen[(i == 0) ? 0 : i - 1]),
        .seen_in    (seen[i]),
        .seen_out   (seen[i+1]),
        .tail_in    (tail[i]),
        .tail_out   (tail[i+1]),
        .data       (data[i])
      );
    end
  endgenerate

  always_comb begin
    state_next  = state;
    count_next  = count;
    rem_next    = rem;
    load        = 1'b0;
    ctrl.cmd    = bdq_pkg::CMD_NONE;
    ctrl.value  = s_tdata[34:3];
    ctrl.key    = s_tdata[66:35];
    res_status  = bdq_pkg::ST_OK;
    res_element = '0;
    res_last    = 1'b1;
    if (accept) begin
      load = 1'b1;
      unique case (func)
        bdq_pkg::FN_PUSH_FRONT, bdq_pkg::FN_PUSH_BACK: begin
          if (full) begin
            res_status = bdq_pkg::ST_FULL;
          end else begin
            ctrl.cmd   = (func == bdq_pkg::FN_PUSH_FRONT) ? bdq_pkg::CMD_PUSH_FRONT
                                                          : bdq_pkg::CMD_PUSH_BACK;
            count_next = count + CW'(1);
          end
        end
        bdq_pkg::FN_INSERT: begin
          if (empty) begin
            res_status = bdq_pkg::ST_EMPTY;
          end else if (!found) begin
            res_status = bdq_pkg::ST_NOTFOUND;
          end else if (full) begin
            res_status = bdq_pkg::ST_FULL;
          end else begin
            ctrl.cmd   = bdq_pkg::CMD_INSERT;
            count_next = count + CW'(1);
          end
        end
        bdq_pkg::FN_POP_FRONT: begin
          if (empty) begin
            res_status = bdq_pkg::ST_EMPTY;
          end else begin
            ctrl.cmd    = bdq_pkg::CMD_ROTATE;
            res_element = head;
            count_next  = count - CW'(1);
          end
        end
        bdq_pkg::FN_POP_BACK: begin
          if (empty) begin
            res_status = bdq_pkg::ST_EMPTY;
          end else begin
            res_element = tail[CAPACITY];
            count_next  = count - CW'(1);
          end
        end
        bdq_pkg::FN_READ_ALL: begin
          if (empty) begin
            res_status = bdq_pkg::ST_EMPTY;
          end else begin
            ctrl.cmd    = bdq_pkg::CMD_ROTATE;
            res_element = head;
            res_last    = count == CW'(1);
            if (count != CW'(1)) begin
              state_next = S_READ;
              rem_next   = count - CW'(1);
            end
          end
        end
        default: begin
          res_status = bdq_pkg::ST_OK;
        end
      endcase
    end else if ((state == S_READ) && free) begin
      load        = 1'b1;
      ctrl.cmd    = bdq_pkg::CMD_ROTATE;
      res_element = head;
      res_last    = rem == CW'(1);
      rem_next    = rem - CW'(1);
      if (rem == CW'(1)) begin
        state_next = S_RUN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_RUN;
      count    <= '0;
      rem      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rem   <= rem_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status  <= res_status;
      element <= res_element;
      length  <= 5'(count_next);
      last    <= res_last;
    end
  end

  assign m_tdata = {1'b0, length, element, status};
  assign m_tlast = last;

  `BDQ_ASSERT_ALWAYS(a_count_bound, count <= CW'(CAPACITY), "element count exceeds capacity")
  `BDQ_ASSERT_ALWAYS(a_read_rem, (state != S_READ) || (rem != '0), "read-out with no elements left")
  `BDQ_ASSERT_ALWAYS(a_ready_run, !s_tready || (state == S_RUN), "input ready during read-out")
  `BDQ_ASSERT_NEXT(a_push_grows,
    accept && (func == bdq_pkg::FN_PUSH_BACK) && !full,
    count == $past(count) + CW'(1), "push back did not grow the list")

endmodule
